@@ design/priority_bitmap_task_scheduler_defines.svh @@
// Assertion macros shared by the scheduler RTL.
`ifndef PRIORITY_BITMAP_TASK_SCHEDULER_DEFINES_SVH
`define PRIORITY_BITMAP_TASK_SCHEDULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/pbts_pkg.sv @@
// Types and constants of the priority bitmap task scheduler.
`default_nettype none

package pbts_pkg;

  // Command codes.
  typedef enum logic [3:0] {
    CMD_REGISTER    = 4'd0,
    CMD_KILL        = 4'd1,
    CMD_DELAY       = 4'd2,
    CMD_DELAY_UNTIL = 4'd3,
    CMD_WAIT        = 4'd4,
    CMD_SIGNAL      = 4'd5,
    CMD_WAKEUP      = 4'd6,
    CMD_SUSPEND     = 4'd7,
    CMD_RESUME      = 4'd8,
    CMD_TICK        = 4'd9,
    CMD_SCHEDULE    = 4'd10,
    CMD_YIELD       = 4'd11,
    CMD_LOCK        = 4'd12,
    CMD_UNLOCK      = 4'd13,
    CMD_QUERY       = 4'd14
  } cmd_t;

  // Result status codes.
  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_NOT_PERMITTED = 3'd1;
  localparam logic [2:0] ST_FAILED        = 3'd2;
  localparam logic [2:0] ST_IN_USE        = 3'd3;
  localparam logic [2:0] ST_TIMED_OUT     = 3'd4;

  // Wake causes.
  localparam logic [1:0] CAUSE_OK        = 2'd0;
  localparam logic [1:0] CAUSE_TIMED_OUT = 2'd1;
  localparam logic [1:0] CAUSE_ABORTED   = 2'd2;

  localparam logic [7:0] LOCK_MAX = 8'd255;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [4:0]  task_priority;
    logic [31:0] time_value;
    logic [3:0]  event_index;
    logic        in_interrupt;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  running_priority;
    logic        running_valid;
    logic [31:0] tick_time;
    logic [1:0]  wake_reason;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCHED,
    S_TICK,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic exec;
    logic sched;
    logic tick_step;
    logic load;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic walk_done;
    logic out_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

@@ design/pbts_ctrl.sv @@
// Controller state machine of the scheduler.
`default_nettype none

module pbts_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire pbts_pkg::ctl_sts_t sts,
  output pbts_pkg::ctl_cmd_t      cmd
);
  import pbts_pkg::*;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.is_tick ? S_TICK : S_SCHED;
      end
      S_SCHED: begin
        cmd.sched = 1'b1;
        state_nxt = S_RESP;
      end
      S_TICK: begin
        cmd.tick_step = 1'b1;
        if (sts.walk_done) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ design/pbts_dpath.sv @@
// Datapath of the scheduler: task sets, wake-time memory and result register.
`default_nettype none

module pbts_dpath #(
  parameter int NUM_PRIORITIES = 32,
  parameter int NUM_EVENTS     = 16,
  parameter int TIME_BITS      = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pbts_pkg::in_item_t  in_data,
  input  wire pbts_pkg::ctl_cmd_t  cmd,
  output pbts_pkg::ctl_sts_t       sts,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pbts_pkg::out_item_t      out_data
);
  import pbts_pkg::*;

  localparam int NP = NUM_PRIORITIES;
  localparam int PW = (NP > 1) ? $clog2(NP) : 1;
  localparam int EW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam int TB = TIME_BITS;

  // Highest set bit: {found, index}.
  function automatic logic [PW:0] highest(input logic [NP-1:0] s);
    logic [PW:0] r;
    r = '0;
    for (int i = 0; i < NP; i++) begin
      if (s[i]) r = {1'b1, PW'(i)};
    end
    return r;
  endfunction

  in_item_t        it_r;
  logic [NP-1:0]   valid_r, ready_r, waiting_r, susp_r, sleep_r;
  logic [NP-1:0]   valid_nxt, ready_nxt, waiting_nxt, susp_nxt, sleep_nxt;
  logic [EW-1:0]   waits_ev_r [NP];
  logic [1:0]      cause_r [NP];
  logic [PW-1:0]   run_task_r, run_task_nxt;
  logic            run_flag_r, run_flag_nxt;
  logic [TB-1:0]   tick_r, tick_nxt;
  logic [7:0]      lock_r, lock_nxt;
  logic [2:0]      status_r, status_nxt;
  logic            sched_r, sched_nxt, yield_r, yield_nxt;
  logic [PW:0]     walk_r, walk_nxt;
  logic [PW-1:0]   chk_idx_r;
  logic            chk_v_r;
  logic [TB-1:0]   wt_mem [NP];
  logic [TB-1:0]   wt_rdata_r;
  logic            wt_we;
  logic [PW-1:0]   wt_waddr;
  logic [TB-1:0]   wt_wdata;
  logic            ev_we, cause_we;
  logic [PW-1:0]   cause_addr;
  logic [1:0]      cause_val;
  logic            out_valid_r;
  out_item_t       out_data_r;

  logic [PW-1:0]   p_idx;
  logic            p_ok, ev_ok, self_ok, issue;
  logic [TB-1:0]   tv;
  logic [NP-1:0]   pb, qb, waiters, cb;
  logic [PW:0]     hi_wait, hi_ready, hi_yield;

  assign p_idx   = PW'(it_r.task_priority);
  assign p_ok    = 32'(it_r.task_priority) < NP;
  assign ev_ok   = 32'(it_r.event_index) < NUM_EVENTS;
  assign tv      = TB'(it_r.time_value);
  assign pb      = NP'(1) << p_idx;
  assign qb      = NP'(1) << run_task_r;
  assign cb      = NP'(1) << chk_idx_r;
  assign self_ok = !it_r.in_interrupt && (lock_r == 8'd0) && run_flag_r &&
                   ((ready_r & qb) != '0);
  assign issue   = walk_r < (PW+1)'(NP);

  // Waiters of the addressed event, from each task's recorded event.
  always_comb begin
    for (int i = 0; i < NP; i++) begin
      waiters[i] = waiting_r[i] && valid_r[i] && (waits_ev_r[i] == EW'(it_r.event_index));
    end
  end

  assign hi_wait  = highest(waiters);
  assign hi_ready = highest(ready_r);
  assign hi_yield = highest(ready_r & ~NP'(1) & (qb - NP'(1)));

  // Command execution, scheduler runs and tick walk.
  always_comb begin
    valid_nxt    = valid_r;
    ready_nxt    = ready_r;
    waiting_nxt  = waiting_r;
    susp_nxt     = susp_r;
    sleep_nxt    = sleep_r;
    run_task_nxt = run_task_r;
    run_flag_nxt = run_flag_r;
    tick_nxt     = tick_r;
    lock_nxt     = lock_r;
    status_nxt   = status_r;
    sched_nxt    = sched_r;
    yield_nxt    = yield_r;
    walk_nxt     = walk_r;
    wt_we        = 1'b0;
    wt_waddr     = p_idx;
    wt_wdata     = tv;
    ev_we        = 1'b0;
    cause_we     = 1'b0;
    cause_addr   = p_idx;
    cause_val    = CAUSE_OK;

    if (cmd.exec) begin
      status_nxt = ST_OK;
      sched_nxt  = 1'b0;
      yield_nxt  = 1'b0;
      unique case (it_r.cmd)
        CMD_REGISTER: begin
          if (!p_ok) status_nxt = ST_NOT_PERMITTED;
          else if ((valid_r & pb) != '0) status_nxt = ST_IN_USE;
          else begin
            valid_nxt = valid_r | pb;
            ready_nxt = ready_r | pb;
          end
        end
        CMD_KILL: begin
          if (!self_ok) status_nxt = ST_NOT_PERMITTED;
          else begin
            waiting_nxt = waiting_r & ~qb;
            ready_nxt   = ready_r & ~qb;
            susp_nxt    = susp_r & ~qb;
            sleep_nxt   = sleep_r & ~qb;
            valid_nxt   = valid_r & ~qb;
            sched_nxt   = 1'b1;
          end
        end
        CMD_DELAY, CMD_DELAY_UNTIL: begin
          if (!self_ok || run_task_r == '0) status_nxt = ST_NOT_PERMITTED;
          else if (!(it_r.cmd == CMD_DELAY && tv == '0)) begin
            cause_we   = 1'b1;
            cause_addr = run_task_r;
            cause_val  = CAUSE_OK;
            wt_we      = 1'b1;
            wt_waddr   = run_task_r;
            wt_wdata   = (it_r.cmd == CMD_DELAY_UNTIL) ? tv : (tick_r + tv);
            ready_nxt  = ready_r & ~qb;
            sleep_nxt  = sleep_r | qb;
            sched_nxt  = 1'b1;
          end
        end
        CMD_WAIT: begin
          if (!p_ok || !ev_ok || (ready_r & pb) == '0) status_nxt = ST_NOT_PERMITTED;
          else begin
            cause_we    = 1'b1;
            cause_val   = CAUSE_OK;
            ev_we       = 1'b1;
            ready_nxt   = ready_r & ~pb;
            waiting_nxt = waiting_r | pb;
            if (tv != '0 && tv != '1) begin
              wt_we     = 1'b1;
              wt_wdata  = tick_r + tv;
              sleep_nxt = sleep_r | pb;
            end
            sched_nxt = 1'b1;
          end
        end
        CMD_SIGNAL: begin
          if (!ev_ok) status_nxt = ST_NOT_PERMITTED;
          else if (!hi_wait[PW]) status_nxt = ST_TIMED_OUT;
          else begin
            waiting_nxt = waiting_r & ~(NP'(1) << hi_wait[PW-1:0]);
            sleep_nxt   = sleep_r & ~(NP'(1) << hi_wait[PW-1:0]);
            ready_nxt   = ready_r | (NP'(1) << hi_wait[PW-1:0]);
          end
        end
        CMD_WAKEUP: begin
          if (!p_ok || (valid_r & pb) == '0 || ((sleep_r | waiting_r) & pb) == '0) begin
            status_nxt = ST_NOT_PERMITTED;
          end else begin
            waiting_nxt = waiting_r & ~pb;
            sleep_nxt   = sleep_r & ~pb;
            ready_nxt   = ready_r | pb;
            cause_we    = 1'b1;
            cause_val   = CAUSE_ABORTED;
          end
        end
        CMD_SUSPEND: begin
          if (!self_ok) status_nxt = ST_NOT_PERMITTED;
          else begin
            ready_nxt = ready_r & ~qb;
            susp_nxt  = susp_r | qb;
            sched_nxt = 1'b1;
          end
        end
        CMD_RESUME: begin
          if (!p_ok || (susp_r & pb) == '0) status_nxt = ST_NOT_PERMITTED;
          else begin
            susp_nxt  = susp_r & ~pb;
            ready_nxt = ready_r | pb;
            sched_nxt = 1'b1;
          end
        end
        CMD_TICK: begin
          tick_nxt = tick_r + TB'(1);
          walk_nxt = (PW+1)'(1);
        end
        CMD_SCHEDULE: sched_nxt = 1'b1;
        CMD_YIELD: begin
          if (it_r.in_interrupt || lock_r != 8'd0) status_nxt = ST_NOT_PERMITTED;
          else yield_nxt = 1'b1;
        end
        CMD_LOCK: begin
          if (it_r.in_interrupt) status_nxt = ST_NOT_PERMITTED;
          else if (lock_r != LOCK_MAX) lock_nxt = lock_r + 8'd1;
        end
        CMD_UNLOCK: begin
          if (it_r.in_interrupt) status_nxt = ST_NOT_PERMITTED;
          else if (lock_r == 8'd0) status_nxt = ST_FAILED;
          else begin
            lock_nxt  = lock_r - 8'd1;
            sched_nxt = (lock_r == 8'd1);
          end
        end
        CMD_QUERY: ;
        default: status_nxt = ST_NOT_PERMITTED;
      endcase
    end

    // Scheduler run: highest ready task, or yield's pick below the current one.
    if (cmd.sched) begin
      if (yield_r) begin
        if (hi_yield[PW]) begin
          run_task_nxt = hi_yield[PW-1:0];
          run_flag_nxt = 1'b1;
        end else if (hi_ready[PW]) begin
          run_task_nxt = hi_ready[PW-1:0];
          run_flag_nxt = 1'b1;
        end
      end else if (sched_r && lock_r == 8'd0 && hi_ready[PW]) begin
        run_task_nxt = hi_ready[PW-1:0];
        run_flag_nxt = 1'b1;
      end
    end

    // Tick walk: one wake time read per cycle, compared in the following cycle.
    if (cmd.tick_step) begin
      if (issue) walk_nxt = walk_r + (PW+1)'(1);
      if (chk_v_r && (sleep_r & cb) != '0 && wt_rdata_r == tick_r) begin
        sleep_nxt   = sleep_r & ~cb;
        waiting_nxt = waiting_r & ~cb;
        ready_nxt   = ready_r | cb;
        cause_we    = 1'b1;
        cause_addr  = chk_idx_r;
        cause_val   = CAUSE_TIMED_OUT;
      end
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      ready_r    <= '0;
      waiting_r  <= '0;
      susp_r     <= '0;
      sleep_r    <= '0;
      run_task_r <= '0;
      run_flag_r <= 1'b0;
      tick_r     <= '0;
      lock_r     <= '0;
      sched_r    <= 1'b0;
      yield_r    <= 1'b0;
      walk_r     <= (PW+1)'(NP);
      chk_v_r    <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      ready_r    <= ready_nxt;
      waiting_r  <= waiting_nxt;
      susp_r     <= susp_nxt;
      sleep_r    <= sleep_nxt;
      run_task_r <= run_task_nxt;
      run_flag_r <= run_flag_nxt;
      tick_r     <= tick_nxt;
      lock_r     <= lock_nxt;
      sched_r    <= sched_nxt;
      yield_r    <= yield_nxt;
      walk_r     <= walk_nxt;
      chk_v_r    <= cmd.tick_step && issue;
    end
  end

  // Wake causes reset to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NP; i++) cause_r[i] <= CAUSE_OK;
    end else if (cause_we) begin
      cause_r[cause_addr] <= cause_val;
    end
  end

  // Payload registers: latched item, status, check index, recorded events.
  always_ff @(posedge clk) begin
    if (cmd.accept) it_r <= in_data;
    status_r  <= status_nxt;
    chk_idx_r <= walk_r[PW-1:0];
    if (ev_we) waits_ev_r[p_idx] <= EW'(it_r.event_index);
  end

  // Wake-time memory.
  always_ff @(posedge clk) begin
    if (wt_we) wt_mem[wt_waddr] <= wt_wdata;
    wt_rdata_r <= wt_mem[walk_r[PW-1:0]];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r.status           <= status_r;
      out_data_r.running_priority <= 5'(run_task_r);
      out_data_r.running_valid    <= run_flag_r;
      out_data_r.tick_time        <= 32'(tick_r);
      out_data_r.wake_reason      <= p_ok ? cause_r[p_idx] : CAUSE_OK;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign sts.is_tick   = (it_r.cmd == CMD_TICK);
  assign sts.walk_done = !issue && !chk_v_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

@@ design/priority_bitmap_task_scheduler.sv @@
// Priority bitmap task scheduler, top level.
//
// One command is taken at a time and gives one result. Most commands pass
// latch, execute, scheduler run and result on the way from acceptance to
// the result register. A tick walks the wake-time memory one priority per
// cycle; that walk over the single read port sets the worst case. A
// finished result waits in the output register while the next command is
// taken.
`default_nettype none

module priority_bitmap_task_scheduler #(
  parameter int NUM_PRIORITIES = 32,
  parameter int NUM_EVENTS     = 16,
  parameter int TIME_BITS      = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pbts_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pbts_pkg::out_item_t      out_data
);
  import pbts_pkg::*;

`include "priority_bitmap_task_scheduler_defines.svh"

  ctl_cmd_t ctl_cmd;
  ctl_sts_t ctl_sts;

  // Controller.
  pbts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (ctl_sts),
    .cmd      (ctl_cmd)
  );

  // Datapath.
  pbts_dpath #(
    .NUM_PRIORITIES (NUM_PRIORITIES),
    .NUM_EVENTS     (NUM_EVENTS),
    .TIME_BITS      (TIME_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (ctl_cmd),
    .sts       (ctl_sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // An accepted item keeps the input closed until its result is loaded.
  `PBTS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted while busy")
  // A waiting result is never overwritten.
  `PBTS_ASSERT_NOW(a_load_free, ctl_cmd.load, !out_valid || !out_stall, "result overwritten")
  // The wake-time walk runs only for a tick command.
  `PBTS_ASSERT_NOW(a_walk_tick, ctl_cmd.tick_step, ctl_sts.is_tick, "walk without tick")

endmodule

`default_nettype wire
